// ===== hdl/abqp_pkg.sv =====
// ----------------------------------------------------------------------------
// abqp_pkg
// Shared types and constants of the analog button qualifier with passcode.
// ----------------------------------------------------------------------------
package abqp_pkg;

	localparam int HISTORY_LEN = 6;
	localparam logic [2:0] HIST_FULL = 3'(HISTORY_LEN);

	localparam logic [1:0] ST_OFF   = 2'd0;
	localparam logic [1:0] ST_ON    = 2'd1;
	localparam logic [1:0] ST_PRESS = 2'd2;

	localparam logic [1:0] MODE_PLAIN    = 2'd0;
	localparam logic [1:0] MODE_PRESENCE = 2'd1;
	localparam logic [1:0] MODE_PASSCODE = 2'd2;

	localparam logic [2:0] REG_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_ON        = 3'd1;
	localparam logic [2:0] REG_PRESS     = 3'd2;
	localparam logic [2:0] REG_OFF       = 3'd3;
	localparam logic [2:0] REG_ERROR     = 3'd4;
	localparam logic [2:0] REG_ALPHA     = 3'd5;
	localparam logic [2:0] REG_MODE      = 3'd6;
	localparam logic [2:0] REG_TIMEOUT   = 3'd7;

	// newest entry in the low bits: ON OFF ON PRESS OFF ON, oldest first
	localparam logic [2*HISTORY_LEN-1:0] PASSCODE =
		{ST_ON, ST_OFF, ST_ON, ST_PRESS, ST_OFF, ST_ON};

	// millivolts = v * 5000 / 1023, the divide as a reciprocal multiply
	localparam logic [12:0] MV_SCALE = 13'd5000;
	localparam logic [23:0] MV_RECIP = 24'd8396809;
	localparam int          MV_SHIFT = 33;

	localparam logic [12:0] RST_THRESHOLD = 13'd2500;
	localparam logic [15:0] RST_ON        = 16'd10;
	localparam logic [15:0] RST_PRESS     = 16'd100;
	localparam logic [15:0] RST_OFF       = 16'd10;
	localparam logic [15:0] RST_ERROR     = 16'd3000;
	localparam logic [8:0]  RST_ALPHA     = 9'd26;
	localparam logic [1:0]  RST_MODE      = MODE_PASSCODE;
	localparam logic [15:0] RST_TIMEOUT   = 16'd1500;

	typedef struct packed {
		logic [12:0] threshold_mv;
		logic [15:0] on_ticks;
		logic [15:0] press_ticks;
		logic [15:0] off_ticks;
		logic [15:0] error_ticks;
		logic [8:0]  alpha_q8;
		logic [1:0]  mode;
		logic [15:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  button_state;
		logic [9:0]  smoothed_value;
		logic [12:0] level_mv;
		logic        stuck_flag;
		logic        locked_out;
		logic        unlock_pulse;
	} result_t;

endpackage

// ===== hdl/analog_button_qualifier_passcode.sv =====
// ----------------------------------------------------------------------------
// analog_button_qualifier_passcode
// Analog button qualifier with passcode unlock: queued ADC ticks in, queued
// status results out, register write port for thresholds and timing.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  input    push / full          raw_sample
//  result   pop / empty          button_state, smoothed_value, level_mv,
//                                stuck_flag, locked_out, unlock_pulse
//  config   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Each tick walks the core sequencer: an update state, S_MV1 and S_MV2 for
//  the millivolt multiply chain, then a state that pushes the result.
//  Input and result queues hold QUEUE_DEPTH transactions each; a full
//  result queue stalls the core, a full input queue raises full.
//  Reset is asynchronous; queue storage, passcode history and the pulse are not reset.
//  cfg_ready is always high.
module analog_button_qualifier_passcode #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [9:0]  raw_sample,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  button_state,
	output logic [9:0]  smoothed_value,
	output logic [12:0] level_mv,
	output logic        stuck_flag,
	output logic        locked_out,
	output logic        unlock_pulse,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	abqp_pkg::cfg_t    cfg_q;
	abqp_pkg::result_t core_res, res;
	logic              in_empty, in_pop, out_full, out_push;
	logic [9:0]        in_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_mv  <= abqp_pkg::RST_THRESHOLD;
			cfg_q.on_ticks      <= abqp_pkg::RST_ON;
			cfg_q.press_ticks   <= abqp_pkg::RST_PRESS;
			cfg_q.off_ticks     <= abqp_pkg::RST_OFF;
			cfg_q.error_ticks   <= abqp_pkg::RST_ERROR;
			cfg_q.alpha_q8      <= abqp_pkg::RST_ALPHA;
			cfg_q.mode          <= abqp_pkg::RST_MODE;
			cfg_q.timeout_ticks <= abqp_pkg::RST_TIMEOUT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				abqp_pkg::REG_THRESHOLD: cfg_q.threshold_mv  <= cfg_data[12:0];
				abqp_pkg::REG_ON:        cfg_q.on_ticks      <= cfg_data;
				abqp_pkg::REG_PRESS:     cfg_q.press_ticks   <= cfg_data;
				abqp_pkg::REG_OFF:       cfg_q.off_ticks     <= cfg_data;
				abqp_pkg::REG_ERROR:     cfg_q.error_ticks   <= cfg_data;
				abqp_pkg::REG_ALPHA:     cfg_q.alpha_q8      <= cfg_data[8:0];
				abqp_pkg::REG_MODE:      cfg_q.mode          <= cfg_data[1:0];
				abqp_pkg::REG_TIMEOUT:   cfg_q.timeout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	abqp_fifo #(
		.WIDTH(10),
		.DEPTH(QUEUE_DEPTH)
	) u_in_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (raw_sample),
		.full  (full),
		.pop   (in_pop),
		.dout  (in_data),
		.empty (in_empty)
	);

	abqp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_empty(in_empty),
		.in_data (in_data),
		.in_pop  (in_pop),
		.out_full(out_full),
		.out_push(out_push),
		.out_data(core_res)
	);

	abqp_fifo #(
		.WIDTH($bits(abqp_pkg::result_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.din   (core_res),
		.full  (out_full),
		.pop   (pop),
		.dout  (res),
		.empty (empty)
	);

	assign button_state   = res.button_state;
	assign smoothed_value = res.smoothed_value;
	assign level_mv       = res.level_mv;
	assign stuck_flag     = res.stuck_flag;
	assign locked_out     = res.locked_out;
	assign unlock_pulse   = res.unlock_pulse;

endmodule

// ===== hdl/abqp_fifo.sv =====
// ----------------------------------------------------------------------------
// abqp_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module abqp_fifo #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = cnt_q == CW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/abqp_core.sv =====
// ----------------------------------------------------------------------------
// abqp_core
// Per-tick sequencer: hold counter, classification, passcode history,
// low-pass filter and millivolt conversion.
// ----------------------------------------------------------------------------
module abqp_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  abqp_pkg::cfg_t         cfg,
	input  logic                   in_empty,
	input  logic [9:0]             in_data,
	output logic                   in_pop,
	input  logic                   out_full,
	output logic                   out_push,
	output abqp_pkg::result_t      out_data
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MV1  = 4'b0010,
		S_MV2  = 4'b0100,
		S_OUT  = 4'b1000
	} core_state_t;

	core_state_t state_q;

	logic [9:0]  filt_q;
	logic [15:0] hold_q, idle_q, lock_q;
	logic [1:0]  cur_q;
	logic        stuck_q;
	logic [2*abqp_pkg::HISTORY_LEN-1:0] hist_q;
	logic [2:0]  fill_q;
	logic [12:0] level_q;
	logic        pulse_q;
	logic [22:0] prod_s1;
	logic [46:0] recip_prod;

	logic        take, low, pm, was_locked, wrote;
	logic [15:0] hold_n, idle_n, lock_n;
	logic [1:0]  st, cur_n;
	logic        stuck_n, pulse_n;
	logic [2*abqp_pkg::HISTORY_LEN-1:0] hist_n;
	logic [2:0]  fill_n;
	logic [8:0]  alpha;
	logic [9:0]  diff, step, filt_n;
	logic [18:0] fprod;

	assign take     = (state_q == S_IDLE) && !in_empty;
	assign in_pop   = take;
	assign out_push = (state_q == S_OUT) && !out_full;
	assign low      = level_q <= cfg.threshold_mv;
	assign pm       = cfg.mode == abqp_pkg::MODE_PASSCODE;

	always_comb begin
		idle_n     = (idle_q != '0) ? idle_q - 16'd1 : idle_q;
		was_locked = lock_q != '0;
		lock_n     = was_locked ? lock_q - 16'd1 : lock_q;
		fill_n     = (was_locked && lock_n == '0) ? 3'd0 : fill_q;
		hist_n     = hist_q;
		if (low || cur_q != abqp_pkg::ST_OFF) begin
			hold_n = (hold_q == 16'hFFFF) ? hold_q : hold_q + 16'd1;
		end else begin
			hold_n = '0;
		end
		stuck_n = stuck_q;
		st      = cur_q;
		cur_n   = cur_q;
		pulse_n = 1'b0;
		wrote   = 1'b0;
		if (hold_n >= cfg.error_ticks) begin
			stuck_n = 1'b1;
		end else if (!(pm && was_locked)) begin
			if (pm && idle_n == '0 && fill_n != '0) begin
				fill_n = 3'd0;
			end
			if (cfg.mode != abqp_pkg::MODE_PRESENCE && hold_n >= cfg.press_ticks && low) begin
				st    = abqp_pkg::ST_PRESS;
				wrote = 1'b1;
			end else if (hold_n >= cfg.on_ticks && low) begin
				st    = abqp_pkg::ST_ON;
				wrote = 1'b1;
			end else if (hold_n >= cfg.off_ticks && !low) begin
				st    = abqp_pkg::ST_OFF;
				wrote = 1'b1;
			end
			if (pm) begin
				if (wrote && fill_n < abqp_pkg::HIST_FULL &&
				    (fill_n == '0 || hist_n[1:0] != st)) begin
					hist_n = {hist_n[2*abqp_pkg::HISTORY_LEN-3:0], st};
					fill_n = fill_n + 3'd1;
					idle_n = cfg.timeout_ticks;
				end
				if (fill_n >= abqp_pkg::HIST_FULL) begin
					if (hist_n == abqp_pkg::PASSCODE) begin
						pulse_n = 1'b1;
						fill_n  = 3'd0;
					end else begin
						lock_n = (cfg.timeout_ticks != '0) ? cfg.timeout_ticks : 16'd1;
						st     = abqp_pkg::ST_OFF;
					end
				end
			end
			cur_n = st;
		end
	end

	always_comb begin
		alpha = (cfg.alpha_q8[8] && cfg.alpha_q8[7:0] != '0) ? 9'd256 : cfg.alpha_q8;
		diff  = (in_data >= filt_q) ? in_data - filt_q : filt_q - in_data;
		fprod = 19'(alpha) * 19'(diff);
		step  = fprod[17:8];
		filt_n = (in_data >= filt_q) ? filt_q + step : filt_q - step;
	end

	assign recip_prod = 47'(prod_s1) * 47'(abqp_pkg::MV_RECIP);

	always_ff @(posedge clk) begin
		if (take) begin
			hist_q  <= hist_n;
			pulse_q <= pulse_n;
		end
		if (state_q == S_MV1) begin
			prod_s1 <= 23'(filt_q) * 23'(abqp_pkg::MV_SCALE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			filt_q  <= '0;
			hold_q  <= '0;
			idle_q  <= '0;
			lock_q  <= '0;
			cur_q   <= abqp_pkg::ST_OFF;
			stuck_q <= 1'b0;
			fill_q  <= '0;
			level_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						filt_q  <= filt_n;
						hold_q  <= hold_n;
						idle_q  <= idle_n;
						lock_q  <= lock_n;
						cur_q   <= cur_n;
						stuck_q <= stuck_n;
						fill_q  <= fill_n;
						state_q <= S_MV1;
					end
				end
				S_MV1: begin
					state_q <= S_MV2;
				end
				S_MV2: begin
					level_q <= recip_prod[abqp_pkg::MV_SHIFT+12:abqp_pkg::MV_SHIFT];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		out_data.button_state   = cur_q;
		out_data.smoothed_value = filt_q;
		out_data.level_mv       = level_q;
		out_data.stuck_flag     = stuck_q;
		out_data.locked_out     = lock_q != '0;
		out_data.unlock_pulse   = pulse_q;
	end

endmodule

// ===== hdl/abqp_checker.sv =====
// ----------------------------------------------------------------------------
// abqp_checker
// Port-level assertions for the analog button qualifier, bound to the top.
// ----------------------------------------------------------------------------
module abqp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  button_state,
	input logic [9:0]  smoothed_value,
	input logic [12:0] level_mv,
	input logic        stuck_flag,
	input logic        locked_out,
	input logic        unlock_pulse
);
	logic seen_stuck_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_stuck_q <= 1'b0;
		end else if (pop && !empty && stuck_flag) begin
			seen_stuck_q <= 1'b1;
		end
	end

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(button_state) &&
		$stable(smoothed_value) && $stable(level_mv) && $stable(stuck_flag) &&
		$stable(locked_out) && $stable(unlock_pulse)))
		else $error("result changed while waiting");

	a_unlock: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && unlock_pulse) |-> (!locked_out && button_state == abqp_pkg::ST_ON))
		else $error("unlock transaction with lockout or wrong status");

	a_stuck_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && seen_stuck_q) |-> stuck_flag)
		else $error("stuck flag cleared after being reported");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (level_mv <= 13'd5000 && button_state != 2'd3))
		else $error("result field out of range");

endmodule

bind analog_button_qualifier_passcode abqp_checker u_abqp_checker (.*);
